// ----- src/tcw_pkg.sv -----
`default_nettype none
package tcw_pkg;

	// store depth in cells, a power of two
	localparam int MEM_CELLS = 8192;
	localparam int ADDR_W    = $clog2(MEM_CELLS);
	// origin may run one row past the store end before the wrap check
	localparam int ORG_W     = $clog2(MEM_CELLS + 256);
	// origin plus a full screen of rows plus a column
	localparam int OFF_W     = $clog2(MEM_CELLS + 16640);
	// row times columns
	localparam int PROD_W    = 14;
	localparam int CNT_W     = 14;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_HOME  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// character codes
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_PRINT_HI = 8'd126;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_VT       = 8'd11;
	localparam logic [7:0] CH_FF       = 8'd12;
	localparam logic [7:0] CH_CR       = 8'd13;

	// register indexes
	localparam logic [2:0] CFG_COLUMNS   = 3'd0;
	localparam logic [2:0] CFG_LINES     = 3'd1;
	localparam logic [2:0] CFG_ATTRIBUTE = 3'd2;
	localparam logic [2:0] CFG_ERASE     = 3'd3;
	localparam logic [2:0] CFG_HOME_COL  = 3'd4;
	localparam logic [2:0] CFG_HOME_ROW  = 3'd5;

	// register reset values
	localparam logic [7:0]  RST_COLUMNS   = 8'd80;
	localparam logic [5:0]  RST_LINES     = 6'd25;
	localparam logic [7:0]  RST_ATTRIBUTE = 8'h07;
	localparam logic [15:0] RST_ERASE     = 16'h0720;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  char_code;
		logic [12:0] cell_address;
	} req_t;

	typedef struct packed {
		logic [12:0] display_start;
		logic [13:0] cursor_cell;
		logic [7:0]  cursor_column;
		logic [5:0]  cursor_row;
		logic [15:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] value;
	} cfg_t;

	// store offset to cell address, modulo the store depth
	function automatic logic [ADDR_W-1:0] cell_at(input logic [OFF_W-1:0] off);
		return off[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- src/tcw_if.sv -----
`default_nettype none
interface tcw_req_if import tcw_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/tcw_ram.sv -----
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/text_console_writer_unit.sv -----
`default_nettype none
// Text console writer. Requests come in on req: write a character, home the
// cursor, or read one cell of the text store. Each accepted request gives
// exactly one transaction on rsp with the display origin, the cursor cell,
// column and row, and the read cell (zero unless a read was asked for).
// Registers are written on cfg at any time, which is always ready; they
// should only change while no request is in flight.
// A line feed on the last row also erases the new bottom row, and a scroll
// that wraps to the start of the store also copies the screen body there.
// req.ready rises in the cycle the result appears, so a new request is
// taken only once the result of the last one has been loaded into rsp.
// The store has a single write port, and the cursor and scroll arithmetic
// share one row-times-columns multiplier.
// After reset the block sweeps all MEM_CELLS (8192) cells of the store to
// zero, one cell a cycle, and holds req.ready low during the sweep.
// rsp has a one-entry output register: a new request is accepted while a
// result waits, and the sequencer holds in its last step until rsp drains.
module text_console_writer_unit import tcw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tcw_req_if.sink    req,
	tcw_rsp_if.source  rsp,
	tcw_cfg_if.sink    cfg
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DISP, S_RD, S_RDW, S_LF, S_SC1, S_SC2, S_SCCHK,
		S_CPRD, S_CPWR, S_ER, S_WMUL, S_WR, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0]  columns_q;
	logic [5:0]  lines_q;
	logic [7:0]  attr_q;
	logic [15:0] erase_q;
	logic [7:0]  home_col_q;
	logic [7:0]  home_row_q;

	// console state
	logic [ORG_W-1:0] origin_q;
	logic [7:0]       col_q;
	logic [5:0]       row_q;

	// working registers
	req_t              item_q;
	logic [15:0]       rd_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] body_q;
	logic [OFF_W-1:0]  base_q;
	logic [CNT_W-1:0]  i_q;
	logic [ADDR_W-1:0] clr_q;
	rsp_t              out_q;
	logic              out_valid_q;

	// shared multiplier and ram control
	logic [5:0]        mul_a;
	logic [PROD_W-1:0] mul_p;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	logic              printable;
	logic [OFF_W-1:0]  origin_ext;
	logic [OFF_W-1:0]  cursor_off;
	logic [OFF_W-1:0]  screen_end;
	logic              out_free;

	assign printable  = (item_q.char_code >= CH_PRINT_LO) && (item_q.char_code <= CH_PRINT_HI);
	assign origin_ext = OFF_W'(origin_q);
	assign cursor_off = origin_ext + OFF_W'(prod_q) + OFF_W'(col_q);
	assign screen_end = origin_ext + OFF_W'(prod_q);
	assign out_free   = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// multiplier operand select
	always_comb begin
		case (state_q)
			S_SC1:   mul_a = (lines_q == 6'd0) ? 6'd0 : lines_q - 6'd1;
			S_SC2:   mul_a = lines_q;
			default: mul_a = row_q;
		endcase
		mul_p = PROD_W'(mul_a) * PROD_W'(columns_q);
	end

	// store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_RD: begin
				ram_re    = 1'b1;
				ram_raddr = cell_at(OFF_W'(item_q.cell_address));
			end
			S_CPRD: begin
				ram_re    = 1'b1;
				ram_raddr = cell_at(origin_ext + OFF_W'(i_q));
			end
			S_CPWR: begin
				ram_we    = 1'b1;
				ram_waddr = cell_at(OFF_W'(i_q));
				ram_wdata = ram_rdata;
			end
			S_ER: begin
				ram_we    = (i_q != CNT_W'(columns_q));
				ram_waddr = cell_at(base_q + OFF_W'(i_q));
				ram_wdata = erase_q;
			end
			S_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cell_at(cursor_off);
				ram_wdata = {attr_q, item_q.char_code};
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(MEM_CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer, console state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			columns_q   <= RST_COLUMNS;
			lines_q     <= RST_LINES;
			attr_q      <= RST_ATTRIBUTE;
			erase_q     <= RST_ERASE;
			home_col_q  <= '0;
			home_row_q  <= '0;
			origin_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			item_q      <= '0;
			rd_q        <= '0;
			prod_q      <= '0;
			body_q      <= '0;
			base_q      <= '0;
			i_q         <= '0;
			clr_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// register writes
			if (cfg.valid) begin
				case (cfg.data.index)
					CFG_COLUMNS:   columns_q  <= cfg.data.value[7:0];
					CFG_LINES:     lines_q    <= cfg.data.value[5:0];
					CFG_ATTRIBUTE: attr_q     <= cfg.data.value[7:0];
					CFG_ERASE:     erase_q    <= cfg.data.value;
					CFG_HOME_COL:  home_col_q <= cfg.data.value[7:0];
					CFG_HOME_ROW:  home_row_q <= cfg.data.value[7:0];
					default: begin
					end
				endcase
			end

			// result taken, unless the output step loads the next one
			if (out_valid_q && rsp.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MEM_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						item_q  <= req.data;
						rd_q    <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (item_q.req_type)
						REQ_WRITE: begin
							if (printable) begin
								if (col_q >= columns_q) begin
									col_q   <= col_q - columns_q;
									state_q <= S_LF;
								end else begin
									state_q <= S_WMUL;
								end
							end else if (item_q.char_code == CH_LF || item_q.char_code == CH_VT
									|| item_q.char_code == CH_FF) begin
								state_q <= S_LF;
							end else begin
								if (item_q.char_code == CH_CR) begin
									col_q <= '0;
								end
								state_q <= S_FIN;
							end
						end
						REQ_HOME: begin
							if (!(home_col_q > columns_q || home_row_q >= {2'b00, lines_q})) begin
								col_q <= home_col_q;
								row_q <= home_row_q[5:0];
							end
							state_q <= S_FIN;
						end
						REQ_READ: state_q <= S_RD;
						default:  state_q <= S_FIN;
					endcase
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					rd_q    <= ram_rdata;
					state_q <= S_FIN;
				end
				// line feed: next row, or scroll on the last row
				S_LF: begin
					if ({1'b0, row_q} + 7'd1 < {1'b0, lines_q}) begin
						row_q   <= row_q + 6'd1;
						state_q <= printable ? S_WMUL : S_FIN;
					end else begin
						state_q <= S_SC1;
					end
				end
				S_SC1: begin
					prod_q   <= mul_p;
					origin_q <= origin_q + ORG_W'(columns_q);
					state_q  <= S_SC2;
				end
				S_SC2: begin
					body_q  <= prod_q;
					prod_q  <= mul_p;
					state_q <= S_SCCHK;
				end
				// screen past the store end: copy down to offset zero
				S_SCCHK: begin
					i_q <= '0;
					if (screen_end > OFF_W'(MEM_CELLS)) begin
						if (body_q == '0) begin
							base_q   <= '0;
							origin_q <= '0;
							state_q  <= S_ER;
						end else begin
							state_q <= S_CPRD;
						end
					end else begin
						base_q  <= origin_ext + OFF_W'(body_q);
						state_q <= S_ER;
					end
				end
				S_CPRD: state_q <= S_CPWR;
				S_CPWR: begin
					if (i_q + CNT_W'(1) == CNT_W'(body_q)) begin
						i_q      <= '0;
						base_q   <= OFF_W'(body_q);
						origin_q <= '0;
						state_q  <= S_ER;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_CPRD;
					end
				end
				// blank the new bottom row
				S_ER: begin
					if (i_q == CNT_W'(columns_q)) begin
						state_q <= printable ? S_WMUL : S_FIN;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				S_WMUL: begin
					prod_q  <= mul_p;
					state_q <= S_WR;
				end
				S_WR: begin
					col_q   <= col_q + 8'd1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					prod_q  <= mul_p;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_q.display_start <= origin_ext[12:0];
						out_q.cursor_cell   <= cursor_off[13:0];
						out_q.cursor_column <= col_q;
						out_q.cursor_row    <= row_q;
						out_q.read_data     <= rd_q;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the store is only written by the sweep, copy, erase and character steps
	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLR || state_q == S_CPWR || state_q == S_ER
			|| state_q == S_WR))
		else $error("store written outside a write step");

	// copy destination stays inside the moved body
	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CPWR) |-> (CNT_W'(body_q) > i_q))
		else $error("copy index past body length");

	// after the wrap check the origin never passes the store end
	a_origin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ER || state_q == S_IDLE) |-> (origin_ext <= OFF_W'(MEM_CELLS)))
		else $error("display origin past store end");

	// a result appears only from the output step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output step");

	// a character write advances the column by one
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |=> (col_q == $past(col_q) + 8'd1))
		else $error("column not advanced after character write");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import tcw_pkg::*;

	// predicts the status transaction of every accepted request
	class console_scoreboard;
		bit [15:0] cells [MEM_CELLS];
		int unsigned origin, col, row;
		int unsigned columns, lines, attr, erase, home_col, home_row;
		rsp_t owed_status [$];
		int errors, accepted, checked, scrolls, wrap_copies;

		function new();
			foreach (cells[i]) cells[i] = '0;
			origin = 0;
			col = 0;
			row = 0;
			columns = RST_COLUMNS;
			lines = RST_LINES;
			attr = RST_ATTRIBUTE;
			erase = RST_ERASE;
			home_col = 0;
			home_row = 0;
		endfunction

		task flag(string what);
			$display("testbench: mismatch: %s", what);
			errors++;
		endtask

		function void set_register(logic [2:0] idx, int unsigned v);
			case (idx)
				CFG_COLUMNS:   columns = v & 'hff;
				CFG_LINES:     lines = v & 'h3f;
				CFG_ATTRIBUTE: attr = v & 'hff;
				CFG_ERASE:     erase = v & 'hffff;
				CFG_HOME_COL:  home_col = v & 'hff;
				CFG_HOME_ROW:  home_row = v & 'hff;
				default: ;
			endcase
		endfunction

		function void blank_cells(int unsigned first, int unsigned count);
			for (int unsigned i = 0; i < count; i++)
				cells[ADDR_W'((first + i) % MEM_CELLS)] = erase[15:0];
		endfunction

		// origin moves one row on; a screen past the store end is copied to zero
		function void scroll_screen();
			int unsigned body;
			int unsigned stop;
			body = (lines > 0 ? lines - 1 : 0) * columns;
			origin += columns;
			stop = origin + lines * columns;
			scrolls++;
			if (stop > MEM_CELLS) begin
				for (int unsigned i = 0; i < body; i++)
					cells[ADDR_W'(i % MEM_CELLS)] = cells[ADDR_W'((origin + i) % MEM_CELLS)];
				blank_cells(body, columns);
				origin = 0;
				wrap_copies++;
			end else begin
				blank_cells(origin + body, columns);
			end
		endfunction

		function void advance_line();
			if (row + 1 < lines)
				row++;
			else
				scroll_screen();
		endfunction

		function void type_char(bit [7:0] c);
			if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
				// deferred wrap resolves on the next printable byte
				if (col >= columns) begin
					col -= columns;
					advance_line();
				end
				cells[ADDR_W'((origin + row * columns + col) % MEM_CELLS)] = {attr[7:0], c};
				col = (col + 1) & 'hff;
			end else if (c == CH_LF || c == CH_VT || c == CH_FF) begin
				advance_line();
			end else if (c == CH_CR) begin
				col = 0;
			end
		endfunction

		function int pending();
			return owed_status.size();
		endfunction

		// accepted request transaction
		function void note(req_t r);
			rsp_t e;
			int unsigned spot;
			bit [15:0] rd;
			rd = '0;
			case (r.req_type)
				REQ_WRITE: type_char(r.char_code);
				REQ_HOME: begin
					if (!(home_col > columns || home_row >= lines)) begin
						col = home_col;
						row = home_row;
					end
				end
				REQ_READ: rd = cells[r.cell_address];
				default: ;
			endcase
			spot = origin + row * columns + col;
			e.display_start = origin[12:0];
			e.cursor_cell = spot[13:0];
			e.cursor_column = col[7:0];
			e.cursor_row = row[5:0];
			e.read_data = rd;
			owed_status.push_back(e);
			accepted++;
		endfunction

		// accepted status transaction
		task check(rsp_t got);
			rsp_t e;
			if (owed_status.size() == 0) begin
				flag($sformatf("status transaction with nothing owed: %h", got));
				return;
			end
			e = owed_status.pop_front();
			checked++;
			if (got.display_start !== e.display_start)
				flag($sformatf("display_start %0d, expected %0d (status %0d)",
					got.display_start, e.display_start, checked));
			if (got.cursor_cell !== e.cursor_cell)
				flag($sformatf("cursor_cell %0d, expected %0d (status %0d)",
					got.cursor_cell, e.cursor_cell, checked));
			if (got.cursor_column !== e.cursor_column)
				flag($sformatf("cursor_column %0d, expected %0d (status %0d)",
					got.cursor_column, e.cursor_column, checked));
			if (got.cursor_row !== e.cursor_row)
				flag($sformatf("cursor_row %0d, expected %0d (status %0d)",
					got.cursor_row, e.cursor_row, checked));
			if (got.read_data !== e.read_data)
				flag($sformatf("read_data %h, expected %h (status %0d)",
					got.read_data, e.read_data, checked));
		endtask
	endclass

	logic clk;
	logic arst_n;

	tcw_req_if req_ch();
	tcw_rsp_if rsp_ch();
	tcw_cfg_if cfg_ch();

	text_console_writer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	console_scoreboard sb = new();
	bit quiet;
	int stall_pct;
	int unsigned rsp_hold = 0;
	int settings_done;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard limit on the run
	initial begin
		#200_000_000;
		$display("testbench: timeout, %0d status transactions still owed", sb.pending());
		$display("testbench: done, errors");
		$finish;
	end

	// status sink stalls in random bursts
	always @(negedge clk) begin
		if (rsp_hold > 0)
			rsp_hold--;
		else if (!quiet && $urandom_range(99) < stall_pct)
			rsp_hold = $urandom_range(8, 1);
		rsp_ch.ready = (rsp_hold == 0);
	end

	// status monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check(rsp_ch.data);
	end

	task send_item(req_t it);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data = it;
		do @(posedge clk); while (!req_ch.ready);
		sb.note(it);
	endtask

	// sender holds off until every owed status has come back
	task wait_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task write_register(logic [2:0] idx, int unsigned v);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data.index = idx;
		cfg_ch.data.value = v[15:0];
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_register(idx, v);
	endtask

	task apply_setting(int unsigned cols, int unsigned rows, int unsigned at,
			int unsigned er, int unsigned hc, int unsigned hr);
		wait_drained();
		write_register(CFG_COLUMNS, cols);
		write_register(CFG_LINES, rows);
		write_register(CFG_ATTRIBUTE, at);
		write_register(CFG_ERASE, er);
		write_register(CFG_HOME_COL, hc);
		write_register(CFG_HOME_ROW, hr);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		settings_done++;
	endtask

	// random requests: ctl_pct sets the share of line feeds and returns
	task run_phase(int n, int ctl_pct, int idle_pct);
		req_t it;
		int r;
		int s;
		int gap;
		stall_pct = idle_pct;
		for (int i = 0; i < n; i++) begin
			it.req_type = REQ_WRITE;
			it.char_code = 8'($urandom_range(255));
			it.cell_address = ADDR_W'($urandom_range(MEM_CELLS - 1));
			r = $urandom_range(99);
			s = $urandom_range(99);
			if (r < ctl_pct) begin
				case ($urandom_range(3))
					0: it.char_code = CH_LF;
					1: it.char_code = CH_VT;
					2: it.char_code = CH_FF;
					default: it.char_code = CH_CR;
				endcase
			end else if (s < 70) begin
				it.char_code = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
			end else if (s < 75) begin
				// any byte, mostly ignored ones
			end else if (s < 85) begin
				it.req_type = REQ_HOME;
			end else if (s < 97) begin
				it.req_type = REQ_READ;
				// half the reads land within 6400 cells past the display origin
				if ($urandom_range(1))
					it.cell_address = ADDR_W'((sb.origin + $urandom_range(6400)) % MEM_CELLS);
			end else begin
				it.req_type = REQ_NONE;
			end
			if (i % 97 == 50)
				wait_drained();
			if (!quiet && $urandom_range(99) < idle_pct) begin
				gap = $urandom_range(8, 1);
				@(negedge clk);
				req_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			send_item(it);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		stall_pct = 0;
		quiet = 1'b0;
		settings_done = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed requests on the reset setting
		send_item(req_t'{REQ_READ, 8'd0, 13'd0});
		send_item(req_t'{REQ_WRITE, CH_PRINT_LO, 13'd0});
		send_item(req_t'{REQ_WRITE, CH_PRINT_HI, 13'h1fff});
		send_item(req_t'{REQ_WRITE, 8'd31, 13'd0});
		send_item(req_t'{REQ_WRITE, 8'd127, 13'd0});
		send_item(req_t'{REQ_WRITE, 8'd0, 13'd0});
		send_item(req_t'{REQ_WRITE, 8'd255, 13'h1fff});
		send_item(req_t'{REQ_READ, 8'd0, 13'd1});
		send_item(req_t'{REQ_WRITE, CH_LF, 13'd0});
		send_item(req_t'{REQ_WRITE, CH_VT, 13'd0});
		send_item(req_t'{REQ_WRITE, CH_FF, 13'd0});
		send_item(req_t'{REQ_WRITE, 8'h41, 13'd0});
		send_item(req_t'{REQ_WRITE, CH_CR, 13'd0});
		send_item(req_t'{REQ_READ, 8'hff, 13'd240});
		wait_drained();
		send_item(req_t'{REQ_HOME, 8'hff, 13'h1fff});
		send_item(req_t'{REQ_READ, 8'd0, 13'h1fff});
		send_item(req_t'{REQ_NONE, 8'hff, 13'h1fff});
		send_item(req_t'{REQ_NONE, 8'd0, 13'd0});
		send_item(req_t'{REQ_WRITE, 8'h7e, 13'd0});
		send_item(req_t'{REQ_READ, 8'd0, 13'd0});

		// 128-column, 50-line screen, home on the pending wrap column
		apply_setting(128, 50, 8'hff, 16'hffff, 128, 49);
		run_phase(200, 30, 30);
		// one-cell screen, every line feed scrolls
		apply_setting(1, 1, 0, 0, 0, 0);
		run_phase(80, 20, 20);
		// zero columns: column keeps counting and wraps at 256
		apply_setting(0, 4, 8'h5a, 16'ha5a5, 1, 3);
		run_phase(450, 0, 10);
		// zero lines: every line feed scrolls, wrap copies move nothing
		apply_setting(128, 0, 8'h3c, 16'h1234, 0, 0);
		run_phase(150, 60, 25);
		// short wide screen wraps the store often; home column out of range
		apply_setting(128, 3, 8'h81, 16'h4e2d, 200, 2);
		run_phase(170, 50, 15);
		// random settings, home often out of range
		repeat (3) begin
			apply_setting($urandom_range(128, 1), $urandom_range(50, 1),
				$urandom_range(255), $urandom_range(65535),
				$urandom_range(1) ? $urandom_range(255) : 0,
				$urandom_range(1) ? $urandom_range(255) : 0);
			run_phase(90, 20, $urandom_range(40));
		end
		// back to the reset setting, no idling on either side
		apply_setting(RST_COLUMNS, RST_LINES, RST_ATTRIBUTE, RST_ERASE, 0, 0);
		quiet = 1'b1;
		stall_pct = 0;
		run_phase(130, 25, 0);

		wait_drained();
		repeat (50) @(negedge clk);
		$display("testbench: %0d requests, %0d status transactions checked, %0d settings",
			sb.accepted, sb.checked, settings_done);
		$display("testbench: %0d scrolls, %0d of them copied the screen to the store start",
			sb.scrolls, sb.wrap_copies);
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
src/tcw_pkg.sv
src/tcw_if.sv
src/tcw_ram.sv
src/text_console_writer_unit.sv
verif/testbench.sv
